>>> rtl/core/dtq_pkg.sv
// Package with shared constants and codes for the delta timer queue.
package dtq_pkg;
   localparam int DefEntries   = 8;
   localparam int DefIdBits    = 8;
   localparam int DefCountBits = 16;

   localparam logic [1:0] KIND_TICK   = 2'd0;
   localparam logic [1:0] KIND_INSERT = 2'd1;
   localparam logic [1:0] KIND_POP    = 2'd2;
   localparam logic [1:0] KIND_CANCEL = 2'd3;

   localparam logic [1:0] STAT_DONE = 2'd0;
   localparam logic [1:0] STAT_MISS = 2'd1;
   localparam logic [1:0] STAT_FULL = 2'd2;
   localparam logic [1:0] STAT_TICK = 2'd3;
endpackage

>>> rtl/core/delta_timer_queue_unit.sv
// Top level of the delta-list timer queue: sequencer around one slot memory.
// A tick, a full store, an insert into an empty queue and a pop or cancel on an empty queue
// go from dispatch straight to the response state; a pop that expires also rewrites the next entry.
// Insert and cancel walk the list, reading one entry per visit.
// One item is in work at a time; the response register frees the request side, and the next
// item is taken in the cycle after the response loads. Synchronous active-high reset empties.
module delta_timer_queue_unit #(
   parameter int ENTRIES    = dtq_pkg::DefEntries,
   parameter int ID_BITS    = dtq_pkg::DefIdBits,
   parameter int COUNT_BITS = dtq_pkg::DefCountBits
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // entry_id [7:0], timeout_units [23:8]
   input  logic [1:0]  req_tuser,   // kind [1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // found_id [7:0], counter_now [23:8]
   output logic [1:0]  rsp_tuser    // status [1:0]
);
   import dtq_pkg::*;

   localparam int SW = $clog2(ENTRIES + 1);
   localparam logic [SW-1:0] NIL = SW'(ENTRIES);
   localparam logic [COUNT_BITS-1:0] CMAX = '1;
   localparam int EW = ID_BITS + COUNT_BITS + SW;

   // Sequencer states.
   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_DISP  = 4'd1;
   localparam logic [3:0] S_RD    = 4'd2;   // memory read issued, data next cycle
   localparam logic [3:0] S_WALK  = 4'd3;   // evaluate entry just read
   localparam logic [3:0] S_WR1   = 4'd4;
   localparam logic [3:0] S_WR2   = 4'd5;
   localparam logic [3:0] S_WR3   = 4'd6;
   localparam logic [3:0] S_RSP   = 4'd7;

   // Slot memory holds id, delta and link of each entry.
   logic [EW-1:0] mem [ENTRIES];
   logic [EW-1:0] rdata_ff;
   logic [SW-1:0] raddr;
   logic          we;
   logic [SW-1:0] waddr;
   logic [EW-1:0] wdata;

   always_ff @(posedge clock) begin
      if (we) mem[waddr[$clog2(ENTRIES)-1:0]] <= wdata;
      rdata_ff <= mem[raddr[$clog2(ENTRIES)-1:0]];
   end

   logic [ID_BITS-1:0]    rd_id;
   logic [COUNT_BITS-1:0] rd_dl;
   logic [SW-1:0]         rd_lk, rd_next;
   assign rd_id = rdata_ff[EW-1 -: ID_BITS];
   assign rd_dl = rdata_ff[SW +: COUNT_BITS];
   assign rd_lk = rdata_ff[SW-1:0];
   assign rd_next = (rd_lk < NIL) ? rd_lk : NIL;

   logic [3:0]            state_ff, state_in;
   logic [ENTRIES-1:0]    used_ff, used_in;
   logic [SW-1:0]         head_ff, head_in;
   logic [COUNT_BITS-1:0] cnt_ff, cnt_in, lag_ff, lag_in;
   logic [1:0]            kind_ff, kind_in;
   logic [ID_BITS-1:0]    id_ff, id_in;
   logic [COUNT_BITS-1:0] tmo_ff, tmo_in;
   logic [COUNT_BITS:0]   acc_ff, acc_in;       // running sum, one extra bit
   logic [SW-1:0]         prev_ff, prev_in, cur_ff, cur_in, new_ff, new_in;
   logic [SW-1:0]         steps_ff, steps_in;
   logic [ID_BITS-1:0]    prid_ff, prid_in;     // id of prev entry
   logic [COUNT_BITS-1:0] prdl_ff, prdl_in;     // delta of prev / current entry
   logic [COUNT_BITS-1:0] cdl_ff, cdl_in;       // delta of entry at cur
   logic [ID_BITS-1:0]    cid_ff, cid_in;
   logic [SW-1:0]         clk_ff, clk_in;       // link of entry at cur
   logic                  rsp_v_ff, rsp_v_in;
   logic [1:0]            rst_ff, rst_in;
   logic [ID_BITS-1:0]    rid_ff, rid_in;
   // Response register: holds a transfer while the next item is in work.
   logic [1:0]            rsp_stat_ff, rsp_stat_in;
   logic [ID_BITS-1:0]    rsp_id_ff, rsp_id_in;
   logic [COUNT_BITS-1:0] rsp_cnt_ff, rsp_cnt_in;

   // Free slot search.
   logic [SW-1:0] free_slot;
   always_comb begin
      free_slot = NIL;
      for (int i = ENTRIES - 1; i >= 0; i--)
         if (!used_ff[i]) free_slot = SW'(i);
   end

   function automatic logic [COUNT_BITS-1:0] satw(input logic [COUNT_BITS:0] v);
      satw = v[COUNT_BITS] ? CMAX : v[COUNT_BITS-1:0];
   endfunction

   logic [COUNT_BITS-1:0] dnew;
   assign dnew = ({1'b0, tmo_ff} >= acc_ff) ? tmo_ff - acc_ff[COUNT_BITS-1:0] : '0;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff; used_in = used_ff; head_in = head_ff;
      cnt_in = cnt_ff; lag_in = lag_ff; kind_in = kind_ff; id_in = id_ff;
      tmo_in = tmo_ff; acc_in = acc_ff; prev_in = prev_ff; cur_in = cur_ff;
      new_in = new_ff; steps_in = steps_ff; prid_in = prid_ff; prdl_in = prdl_ff;
      cdl_in = cdl_ff; cid_in = cid_ff; clk_in = clk_ff;
      rsp_v_in = rsp_v_ff; rst_in = rst_ff; rid_in = rid_ff;
      rsp_stat_in = rsp_stat_ff; rsp_id_in = rsp_id_ff; rsp_cnt_in = rsp_cnt_ff;
      raddr = head_ff; we = 1'b0; waddr = '0; wdata = '0;
      if (rsp_v_ff && rsp_tready) rsp_v_in = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               kind_in = req_tuser;
               id_in = req_tdata[ID_BITS-1:0];
               tmo_in = COUNT_BITS'(req_tdata[23:8]);
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            rst_in = STAT_MISS; rid_in = '0; state_in = S_RSP;
            prev_in = NIL; cur_in = head_ff; steps_in = '0;
            acc_in = {1'b0, cnt_ff};
            raddr = head_ff;
            case (kind_ff)
               KIND_TICK: begin
                  if (cnt_ff != '0) cnt_in = cnt_ff - 1'b1;
                  else if (lag_ff != CMAX) lag_in = lag_ff + 1'b1;
                  rst_in = STAT_TICK;
               end
               KIND_INSERT: begin
                  if (free_slot == NIL) rst_in = STAT_FULL;
                  else begin
                     new_in = free_slot;
                     used_in[free_slot[$clog2(ENTRIES)-1:0]] = 1'b1;
                     rst_in = STAT_DONE;
                     if (head_ff == NIL) begin
                        we = 1'b1; waddr = free_slot;
                        wdata = {id_ff, {COUNT_BITS{1'b0}}, NIL};
                        head_in = free_slot; cnt_in = tmo_ff; lag_in = '0;
                     end else if (cnt_ff > tmo_ff) begin
                        // Preempt: new head; old head gets the difference.
                        we = 1'b1; waddr = free_slot;
                        wdata = {id_ff, {COUNT_BITS{1'b0}}, head_ff};
                        cur_in = head_ff; prdl_in = cnt_ff - tmo_ff;
                        head_in = free_slot; cnt_in = tmo_ff; lag_in = '0;
                        state_in = S_RD; steps_in = NIL;  // marks preempt fixup
                     end else state_in = S_RD;
                  end
               end
               KIND_POP: begin
                  if (head_ff != NIL && cnt_ff == '0) state_in = S_RD;
               end
               default: begin
                  if (head_ff != NIL) state_in = S_RD;
               end
            endcase
         end
         S_RD: begin
            raddr = cur_ff;     // read issued here, result in rdata_ff next
            state_in = S_WALK;
         end
         S_WALK: begin
            cid_in = rd_id; cdl_in = rd_dl; clk_in = rd_next;
            case (kind_ff)
               KIND_INSERT: begin
                  if (steps_ff == NIL && prev_ff == NIL) begin
                     // Preempt fixup of old head's delta.
                     we = 1'b1; waddr = cur_ff; wdata = {rd_id, prdl_ff, rd_lk};
                     state_in = S_RSP;
                  end else if (prev_ff == NIL) begin
                     // At head: acc already holds counter; step onward.
                     prev_in = cur_ff; prid_in = rd_id; prdl_in = rd_dl;
                     clk_in = rd_next; cur_in = rd_next; steps_in = SW'(1);
                     if (rd_next == NIL) state_in = S_WR1;
                     else state_in = S_RD;
                  end else begin
                     // cur is a real entry; acc excludes it so far.
                     if (acc_ff + rd_dl > {1'b0, tmo_ff} || steps_ff >= NIL)
                        state_in = S_WR1;
                     else begin
                        acc_in = acc_ff + rd_dl;
                        prev_in = cur_ff; prid_in = rd_id; prdl_in = rd_dl;
                        clk_in = rd_next; cur_in = rd_next;
                        steps_in = steps_ff + 1'b1;
                        if (rd_next == NIL) state_in = S_WR1;
                        else state_in = S_RD;
                     end
                  end
               end
               KIND_POP: begin
                  rid_in = rd_id; rst_in = STAT_DONE;
                  used_in[cur_ff[$clog2(ENTRIES)-1:0]] = 1'b0;
                  head_in = rd_next; prev_in = cur_ff;
                  if (rd_next != NIL) begin
                     cur_in = rd_next; state_in = S_WR2;
                  end else state_in = S_RSP;
               end
               default: begin
                  if (rd_id == id_ff) begin
                     rid_in = rd_id; rst_in = STAT_DONE;
                     used_in[cur_ff[$clog2(ENTRIES)-1:0]] = 1'b0;
                     if (prev_ff == NIL) head_in = rd_next;
                     else begin
                        we = 1'b1; waddr = prev_ff; wdata = {prid_ff, prdl_ff, rd_next};
                     end
                     if (rd_next != NIL) begin
                        prdl_in = rd_dl; prev_in = cur_ff; cur_in = rd_next;
                        state_in = S_WR2;
                     end else state_in = S_RSP;
                  end else if (rd_next == NIL || steps_ff + 1'b1 >= NIL) begin
                     state_in = S_RSP;
                  end else begin
                     prev_in = cur_ff; prid_in = rd_id; prdl_in = rd_dl;
                     cur_in = rd_next; steps_in = steps_ff + 1'b1;
                     state_in = S_RD;
                  end
               end
            endcase
         end
         S_WR1: begin
            // Link new entry after prev, before cur.
            we = 1'b1; waddr = prev_ff; wdata = {prid_ff, prdl_ff, new_ff};
            if (prev_ff == head_ff && steps_ff == 1) begin
               wdata = {prid_ff, prdl_ff, new_ff};
            end
            state_in = S_WR2;
         end
         S_WR2: begin
            if (kind_ff == KIND_INSERT) begin
               we = 1'b1; waddr = new_ff;
               wdata = {id_ff, dnew, (cur_ff < NIL) ? cur_ff : NIL};
               state_in = (cur_ff < NIL) ? S_WR3 : S_RSP;
            end else begin
               // Successor of removed entry must be read for its delta.
               raddr = cur_ff; state_in = S_WR3;
            end
         end
         S_WR3: begin
            we = 1'b1; waddr = cur_ff; state_in = S_RSP;
            if (kind_ff == KIND_INSERT) begin
               wdata = {cid_ff, (cdl_ff >= dnew) ? cdl_ff - dnew : {COUNT_BITS{1'b0}},
                        clk_ff};
            end else begin
               wdata = {rd_id, {COUNT_BITS{1'b0}}, rd_lk};
               if (kind_ff == KIND_POP) begin
                  cnt_in = (rd_dl > lag_ff) ? rd_dl - lag_ff : '0; lag_in = '0;
               end else if (head_ff == cur_ff) begin
                  cnt_in = satw({1'b0, rd_dl} + cnt_ff); lag_in = '0;
               end else begin
                  wdata = {rd_id, satw({1'b0, rd_dl} + prdl_ff), rd_lk};
               end
            end
         end
         S_RSP: begin
            if (!rsp_v_ff || rsp_tready) begin
               rsp_v_in = 1'b1; state_in = S_IDLE;
               rsp_stat_in = rst_ff; rsp_id_in = rid_ff; rsp_cnt_in = cnt_ff;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Head-cancel detection needs to know whether the removed entry was the head;
   // we track it by the fact that head_ff moved to cur during S_WALK.

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; used_ff <= '0; head_ff <= NIL;
         cnt_ff <= '0; lag_ff <= '0; rsp_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in; used_ff <= used_in; head_ff <= head_in;
         cnt_ff <= cnt_in; lag_ff <= lag_in; rsp_v_ff <= rsp_v_in;
      end
      kind_ff <= kind_in; id_ff <= id_in; tmo_ff <= tmo_in; acc_ff <= acc_in;
      prev_ff <= prev_in; cur_ff <= cur_in; new_ff <= new_in; steps_ff <= steps_in;
      prid_ff <= prid_in; prdl_ff <= prdl_in; cdl_ff <= cdl_in; cid_ff <= cid_in;
      clk_ff <= clk_in; rst_ff <= rst_in; rid_ff <= rid_in;
      rsp_stat_ff <= rsp_stat_in; rsp_id_ff <= rsp_id_in; rsp_cnt_ff <= rsp_cnt_in;
   end

   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tuser  = rsp_stat_ff;
   assign rsp_tdata  = {16'(rsp_cnt_ff), 8'(rsp_id_ff)};

   a_idle_ready: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> state_ff == S_IDLE) else $error("ready outside idle");
   a_head_used: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && head_ff != NIL) |-> used_ff != '0)
      else $error("head set with empty store");
   a_empty_head: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && used_ff == '0) |-> head_ff == NIL)
      else $error("empty store with head");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata) &&
                                        $stable(rsp_tuser)))
      else $error("response changed while waiting");
endmodule

>>> verif/dtq_checker.sv
// Checker for the delta timer queue: predicts each response and compares it.
`timescale 1ns / 1ps
module dtq_checker
   import dtq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [23:0] req_tdata,
   input  logic [1:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [23:0] rsp_tdata,
   input  logic [1:0]  rsp_tuser,
   output int          fail_count,
   output int          pending
);
   localparam int NSLOT = 8;
   localparam int NIL = NSLOT;
   localparam int CMAX = 65535;

   typedef struct packed {
      logic [1:0]  status;
      logic [7:0]  found_id;
      logic [15:0] counter_now;
   } timer_rsp_type;

   logic [7:0]     ids[NSLOT];
   int             deltas[NSLOT];
   int             links[NSLOT];
   bit             busy[NSLOT];
   int             head;
   int             counter;
   int             lag;
   timer_rsp_type  expected_rsps[$];

   assign pending = expected_rsps.size();

   function automatic int sat16(int v);
      return (v > CMAX) ? CMAX : v;
   endfunction

   function automatic int next_of(int s);
      if (s >= NIL) return NIL;
      return (links[s] < NIL) ? links[s] : NIL;
   endfunction

   function automatic void load_counter(int v);
      counter = sat16(v);
      lag = 0;
   endfunction

   function automatic logic [1:0] insert_timer(logic [7:0] id, int tmo);
      int n, prev, cur, steps, acc, d;
      n = NIL;
      for (int i = NSLOT - 1; i >= 0; i--) if (!busy[i]) n = i;
      if (n == NIL) return STAT_FULL;
      busy[n] = 1;
      ids[n] = id;
      if (head >= NIL) begin
         deltas[n] = 0; links[n] = NIL; head = n; load_counter(tmo);
         return STAT_DONE;
      end
      if (counter > tmo) begin
         deltas[n] = 0; links[n] = head; deltas[head] = counter - tmo;
         head = n; load_counter(tmo);
         return STAT_DONE;
      end
      acc = counter; prev = head; cur = head; steps = 0;
      while (acc <= tmo && steps < NIL) begin
         prev = cur;
         cur = next_of(cur);
         steps++;
         if (cur >= NIL) break;
         acc += deltas[cur];
      end
      if (acc > tmo && cur < NIL) acc -= deltas[cur];
      d = (tmo >= acc) ? tmo - acc : 0;
      links[prev] = n;
      deltas[n] = sat16(d);
      links[n] = cur;
      if (cur < NIL) deltas[cur] = (deltas[cur] >= d) ? deltas[cur] - d : 0;
      return STAT_DONE;
   endfunction

   function automatic timer_rsp_type predict_queue(logic [1:0] kind, logic [7:0] id, int tmo);
      timer_rsp_type r;
      int h, nx, prev, cur, steps;
      r.status = STAT_MISS;
      r.found_id = '0;
      case (kind)
         KIND_TICK: begin
            if (counter > 0) counter--;
            else if (lag < CMAX) lag++;
            r.status = STAT_TICK;
         end
         KIND_INSERT: r.status = insert_timer(id, tmo);
         KIND_POP: begin
            h = head;
            if (h < NIL && counter == 0) begin
               nx = next_of(h);
               if (nx < NIL) begin
                  load_counter(deltas[nx] > lag ? deltas[nx] - lag : 0);
                  deltas[nx] = 0;
               end
               head = nx;
               busy[h] = 0;
               r.found_id = ids[h];
               r.status = STAT_DONE;
            end
         end
         default: begin
            prev = NIL; cur = head; steps = 0;
            while (cur < NIL && steps < NIL && ids[cur] != id) begin
               prev = cur;
               cur = next_of(cur);
               steps++;
            end
            if (cur < NIL && ids[cur] == id) begin
               nx = next_of(cur);
               if (prev >= NIL) begin
                  head = nx;
                  if (nx < NIL) begin
                     load_counter(deltas[nx] + counter);
                     deltas[nx] = 0;
                  end
               end else begin
                  links[prev] = nx;
                  if (nx < NIL) deltas[nx] = sat16(deltas[nx] + deltas[cur]);
               end
               busy[cur] = 0;
               r.found_id = ids[cur];
               r.status = STAT_DONE;
            end
         end
      endcase
      r.counter_now = counter[15:0];
      return r;
   endfunction

   always @(posedge clock) begin
      timer_rsp_type want;
      if (reset) begin
         for (int i = 0; i < NSLOT; i++) begin
            busy[i] = 0; links[i] = NIL; deltas[i] = 0; ids[i] = '0;
         end
         head = NIL; counter = 0; lag = 0;
         expected_rsps.delete();
         fail_count <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_rsps.size() == 0) begin
               $display("%0t: response with none expected: status %0d id %0d count %0d",
                        $time, rsp_tuser, rsp_tdata[7:0], rsp_tdata[23:8]);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_rsps.pop_front();
               if (want.status !== rsp_tuser || want.found_id !== rsp_tdata[7:0] ||
                   want.counter_now !== rsp_tdata[23:8]) begin
                  $display("%0t: mismatch expected status %0d id %0d count %0d, got %0d %0d %0d",
                           $time, want.status, want.found_id, want.counter_now,
                           rsp_tuser, rsp_tdata[7:0], rsp_tdata[23:8]);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_tvalid && req_tready)
            expected_rsps.push_back(predict_queue(req_tuser, req_tdata[7:0],
                                                  int'(req_tdata[23:8])));
      end
   end
endmodule

>>> verif/testbench.sv
// Top of the delta timer queue testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module testbench;
   import dtq_pkg::*;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic [1:0]  req_tuser = KIND_TICK;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   int          fail_count;
   int          pending;
   bit          calm = 0;      // When set, neither side idles.
   bit          hold_off = 0;  // When set, the receiver stalls completely.
   bit          stim_done = 0;
   int          idle_cycles = 0;
   int          live_ids[$];   // Ids believed to be pending, for well-aimed cancels.

   delta_timer_queue_unit dut (.*);

   dtq_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // The receiver stalls at random, except during the calm stretch; the
   // hold-off window stops it outright so the block backs up its input.
   always @(posedge clock) begin
      if (reset || hold_off) rsp_tready <= 1'b0;
      else rsp_tready <= calm ? 1'b1 : ($urandom_range(99) >= 22);
   end

   // Watchdog: counts cycles in which no transfer happens on either side.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 5000) begin
         $display("status: fail");
         $finish;
      end
   end

   // Offer one item and wait for its transfer; random gaps before the offer.
   // The valid line drops only when a gap is taken, so back-to-back items
   // keep it high.
   task automatic send_item(logic [1:0] kind, logic [7:0] id, logic [15:0] tmo);
      while (!calm && $urandom_range(99) < 22) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {tmo, id};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Mostly short timeouts so pops really expire; sometimes the full range.
   function automatic logic [15:0] pick_timeout();
      case ($urandom_range(9))
         0: return 16'($urandom_range(65535));
         1: return 16'hFFFF;
         default: return 16'($urandom_range(12));
      endcase
   endfunction

   task automatic random_item();
      int r;
      logic [7:0] id;
      r = $urandom_range(99);
      if (r < 38) send_item(KIND_TICK, 8'($urandom), 16'($urandom));
      else if (r < 65) begin
         id = 8'($urandom_range(255));
         send_item(KIND_INSERT, id, pick_timeout());
         live_ids.push_back(id);
      end else if (r < 85) send_item(KIND_POP, 8'($urandom), 16'($urandom));
      else if (live_ids.size() > 0 && $urandom_range(3) != 0)
         send_item(KIND_CANCEL, 8'(live_ids[$urandom_range(live_ids.size() - 1)]),
                   16'($urandom));
      else send_item(KIND_CANCEL, 8'($urandom), 16'($urandom));
      if (live_ids.size() > 40) live_ids.delete(0);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: empty-queue misses, head preemption, ties, the full
      // store, cancel of head, middle and tail entry, lag and the extremes.
      send_item(KIND_POP, 8'h00, 16'h0000);
      send_item(KIND_CANCEL, 8'h11, 16'h0000);
      send_item(KIND_TICK, 8'h00, 16'h0000);
      send_item(KIND_INSERT, 8'hFF, 16'hFFFF);
      send_item(KIND_INSERT, 8'h01, 16'd5);
      send_item(KIND_INSERT, 8'h02, 16'd5);
      send_item(KIND_INSERT, 8'h03, 16'd9);
      send_item(KIND_INSERT, 8'h02, 16'd7);
      send_item(KIND_INSERT, 8'h00, 16'd0);
      send_item(KIND_INSERT, 8'hAA, 16'd3);
      send_item(KIND_INSERT, 8'h55, 16'd20);
      send_item(KIND_INSERT, 8'h77, 16'd1);
      send_item(KIND_CANCEL, 8'h02, 16'h0000);
      send_item(KIND_CANCEL, 8'h00, 16'h0000);
      send_item(KIND_POP, 8'h00, 16'h0000);
      repeat (4) send_item(KIND_TICK, 8'hFF, 16'hFFFF);
      send_item(KIND_POP, 8'h00, 16'h0000);
      send_item(KIND_CANCEL, 8'h42, 16'h0000);
      send_item(KIND_CANCEL, 8'hFF, 16'h0000);

      // Random part with a calm stretch and one receiver hold-off window.
      for (int n = 0; n < 1150; n++) begin
         calm = (n >= 300 && n < 450);
         if (n == 600) begin
            fork
               begin
                  hold_off = 1;
                  repeat (200) @(posedge clock);
                  hold_off = 0;
               end
            join_none
         end
         random_item();
      end
      req_tvalid <= 1'b0;
      stim_done = 1;
   end

   initial begin
      wait (stim_done);
      while (pending != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (fail_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end
endmodule
